[rtl/core/lsm_pkg.sv]
// ----------------------------------------------------------------------------
// lsm_pkg
// shared types and constants of the line substring matcher: opcodes,
// register indexes and the packed payload structs of both channels
// ----------------------------------------------------------------------------
package lsm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int COL_BITS_DEF    = 16;

  // pattern bytes held by the two 64-bit registers
  localparam int PATTERN_BYTES = 16;
  localparam int FIELD_W       = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int LEN_REG_W     = 5;

  // opcodes
  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_EOL     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] line_index;
    logic [FIELD_W-1:0] column;
  } out_item_t;

endpackage

[rtl/core/lsm_cell.sv]
// ----------------------------------------------------------------------------
// lsm_cell
// one history cell: holds one past text byte, hands it on to the next cell
// on every text byte and compares it against its aligned pattern byte
// ----------------------------------------------------------------------------
module lsm_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic       clear,
  input  logic [7:0] byte_in,
  input  logic       cmp_en,
  input  logic [7:0] expected,
  output logic [7:0] byte_out,
  output logic       eq
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (clear) begin
      held <= 8'd0;
    end else if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign eq       = !cmp_en || (held == expected);

endmodule

[rtl/core/line_substring_matcher_core.sv]
// ----------------------------------------------------------------------------
// line_substring_matcher_core
// streaming search for every occurrence of a configured byte pattern of up
// to PATTERN_MAX bytes inside text lines, reporting line and start column
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | in_data  : op, ch
//  out     | out_valid / out_stall | out_data : line_index, column
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready tied high)
//
//  one transaction per cycle on the input while in_stall is low; each text
//  byte is matched in the cycle it arrives, all window compares run in
//  parallel in the cell chain; a result goes into the output register, or
//  into the skid entry while out stalls, so two results are held; in_stall
//  rises only while both are full, so a waiting result does not block input
//  rst (synchronous) clears counters, history, registers and output valids
//
module line_substring_matcher_core #(
  parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF,
  parameter int LINE_BITS   = lsm_pkg::LINE_BITS_DEF,
  parameter int COL_BITS    = lsm_pkg::COL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lsm_pkg::in_item_t                    in_data,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lsm_pkg::out_item_t                   out_data,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lsm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W   = COL_BITS + 1;
  localparam int CHAIN_N = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int IDX_W   = $clog2(lsm_pkg::PATTERN_BYTES);

  localparam logic [LEN_W-1:0]    LEN_MAX   = LEN_W'(PATTERN_MAX);
  localparam logic [CNT_W-1:0]    COL_MAX   = {1'b0, {COL_BITS{1'b1}}};
  localparam logic [CNT_W-1:0]    COUNT_CAP = COL_MAX + CNT_W'(PATTERN_MAX);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  // configuration registers
  logic [lsm_pkg::LEN_REG_W-1:0]  pattern_len;
  logic [lsm_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [lsm_pkg::CFG_DATA_W-1:0] pattern_high;

  // position counters
  logic [CNT_W-1:0]     column_count;
  logic [LINE_BITS-1:0] line_count;

  // output register and skid entry
  logic               skid_valid;
  lsm_pkg::out_item_t skid_data;

  logic accept, is_text, is_eol, is_restart, out_take;

  logic [LEN_W-1:0]   len_eff;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   start_raw;
  logic [CNT_W-1:0]   start_clamped;
  logic               hit;
  lsm_pkg::out_item_t result;

  logic [lsm_pkg::PATTERN_BYTES-1:0][7:0] pat_bytes;
  logic [PATTERN_MAX-1:0][7:0]            expected;
  logic [PATTERN_MAX-1:0]                 cmp_en;
  logic [CHAIN_N-1:0][7:0]                chain;
  logic [CHAIN_N-1:0]                     cell_eq;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  assign accept     = in_valid && !in_stall;
  assign is_text    = accept && (in_data.op == lsm_pkg::OP_TEXT);
  assign is_eol     = accept && (in_data.op == lsm_pkg::OP_EOL);
  assign is_restart = accept && (in_data.op == lsm_pkg::OP_RESTART);

  // ---------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      pattern_low  <= '0;
      pattern_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsm_pkg::REG_PATTERN_LEN:  pattern_len  <= cfg_data[lsm_pkg::LEN_REG_W-1:0];
        lsm_pkg::REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        lsm_pkg::REG_PATTERN_HIGH: pattern_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // oversized length is clamped to PATTERN_MAX
  always_comb begin
    if (pattern_len > lsm_pkg::LEN_REG_W'(PATTERN_MAX)) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = LEN_W'(pattern_len);
    end
  end

  // ---------------------------------------------------------------------------
  // align the pattern to the window: position j back from the newest byte
  // compares against pattern byte len-1-j, positions at or past len are off
  // ---------------------------------------------------------------------------
  assign pat_bytes = {pattern_high, pattern_low};

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      cmp_en[j]   = (j < int'(len_eff));
      expected[j] = pat_bytes[IDX_W'(int'(len_eff) - 1 - j)];
    end
  end

  // ---------------------------------------------------------------------------
  // history chain: cell k holds the byte k+1 positions before the newest
  // ---------------------------------------------------------------------------
  assign chain[0] = in_data.ch;

  generate
    if (PATTERN_MAX > 1) begin : g_cells
      for (genvar k = 0; k < PATTERN_MAX - 1; k++) begin : g_cell
        if (k < PATTERN_MAX - 2) begin : g_mid
          lsm_cell u_cell (
            .clk      (clk),
            .shift    (is_text),
            .clear    (rst || is_restart),
            .byte_in  (chain[k]),
            .cmp_en   (cmp_en[k+1]),
            .expected (expected[k+1]),
            .byte_out (chain[k+1]),
            .eq       (cell_eq[k])
          );
        end else begin : g_last
          // oldest byte, nothing further down the chain
          lsm_cell u_cell (
            .clk      (clk),
            .shift    (is_text),
            .clear    (rst || is_restart),
            .byte_in  (chain[k]),
            .cmp_en   (cmp_en[k+1]),
            .expected (expected[k+1]),
            .byte_out (),
            .eq       (cell_eq[k])
          );
        end
      end
    end else begin : g_no_cells
      assign cell_eq = 1'b1;
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // match decision and start column
  // ---------------------------------------------------------------------------
  assign count_next = (column_count < COUNT_CAP) ? column_count + 1'b1 : column_count;

  assign hit = is_text
            && (len_eff != '0)
            && (count_next >= CNT_W'(len_eff))
            && (in_data.ch == expected[0])
            && (&cell_eq);

  assign start_raw     = count_next - CNT_W'(len_eff);
  assign start_clamped = (start_raw > COL_MAX) ? COL_MAX : start_raw;

  assign result.line_index = lsm_pkg::FIELD_W'(line_count);
  assign result.column     = lsm_pkg::FIELD_W'(start_clamped);

  // ---------------------------------------------------------------------------
  // line and column counters, both saturating
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || is_restart) begin
      column_count <= '0;
      line_count   <= '0;
    end else if (is_eol) begin
      column_count <= '0;
      if (line_count != LINE_MAX) begin
        line_count <= line_count + 1'b1;
      end
    end else if (is_text) begin
      column_count <= count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry; input stalls only when the skid
  // entry is occupied
  // ---------------------------------------------------------------------------
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no input transaction can happen here
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (hit) begin
      if (!out_valid || out_take) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule
